// ===== design/sacpe_pkg.sv =====
// ============================================================================
// Cache policy engine package
// Shared field widths, register and access codes, and payload structs.
// ============================================================================
package sacpe_pkg;

    // Field widths of the request and response words.
    localparam int FUNC_W     = 1;
    localparam int ADDR_W     = 32;
    localparam int WAY_OUT_W  = 2;
    localparam int CYC_W      = 16;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WRITE_THROUGH  = 2'd0,
        CFG_WRITE_ALLOCATE = 2'd1,
        CFG_LRU            = 2'd2
    } t_cfg_idx;

    // Access kinds.
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_STORE = 1'b1;

    // Largest cycle count that the response can report.
    localparam logic [CYC_W-1:0] CYC_MAX = '1;

    // Mode bits held by the configuration registers.
    typedef struct packed {
        logic wr_thru;
        logic wr_alloc;
        logic lru;
    } t_cfg;

    // One response word.
    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way_used;
        logic                 victim_written_back;
        logic [CYC_W-1:0]     access_cycles;
    } t_rsp;

endpackage

// ===== design/sacpe_req_if.sv =====
// ============================================================================
// Request channel
// Valid/ready channel that carries one access word: kind and byte address.
// ============================================================================
interface sacpe_req_if;

    logic                           valid;
    logic                           ready;
    logic [sacpe_pkg::FUNC_W-1:0]   func;
    logic [sacpe_pkg::ADDR_W-1:0]   address;

    modport source (output valid, output func, output address, input ready);
    modport sink   (input valid, input func, input address, output ready);

endinterface

// ===== design/sacpe_rsp_if.sv =====
// ============================================================================
// Response channel
// Valid/ready channel that carries one result word of the policy engine.
// ============================================================================
interface sacpe_rsp_if;

    logic                              valid;
    logic                              ready;
    logic                              hit;
    logic [sacpe_pkg::WAY_OUT_W-1:0]   way_used;
    logic                              victim_written_back;
    logic [sacpe_pkg::CYC_W-1:0]       access_cycles;

    modport source (output valid, output hit, output way_used,
                    output victim_written_back, output access_cycles, input ready);
    modport sink   (input valid, input hit, input way_used,
                    input victim_written_back, input access_cycles, output ready);

endinterface

// ===== design/set_assoc_cache_policy_engine.sv =====
// ============================================================================
// Set-associative cache policy engine
// Tag compare, fill, LRU/FIFO eviction and cost accounting for a cache.
// ============================================================================
// Usage:
//   i_req carries one access word (func: load or store, byte address).
//   o_rsp returns one result word per access: hit, way used, whether a dirty
//   victim was written back, and the cycles charged for the access.
//   The configuration port writes the write-through, write-allocate and LRU
//   mode bits; write it only while no access is in flight.
// Pipeline:
//   A word accepted on i_req is held in the lookup stage and then registered
//   on o_rsp. One word is accepted every cycle while o_rsp is not stalled. The
//   set row is read from the set RAM at the acceptance edge and written back
//   when the result is registered; back-to-back accesses to one set are forwarded.
// Reset:
//   All lines become invalid, ranks equal the way index, FIFO pointers are
//   zero (a per-set init flag substitutes these values until a set is first
//   written), and the modes return to write-back, write-allocate, LRU.
// Stall:
//   While o_rsp is stalled the result holds, one more access may sit in the
//   lookup stage, and i_req.ready drops once that stage is full.
// ============================================================================
module set_assoc_cache_policy_engine #(
    parameter int NUM_SETS     = 64,
    parameter int NUM_WAYS     = 4,
    parameter int BLOCK_BYTES  = 16,
    parameter int ADDRESS_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [sacpe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sacpe_pkg::CFG_DATA_W-1:0]    i_cfg_wr_data,
    sacpe_req_if.sink                           i_req,
    sacpe_rsp_if.source                         o_rsp
);

    localparam int OFF_W     = $clog2(BLOCK_BYTES);
    localparam int SET_W     = $clog2(NUM_SETS);
    localparam int SET_IW    = (SET_W > 0) ? SET_W : 1;
    localparam int WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int AW        = (ADDRESS_BITS < sacpe_pkg::ADDR_W) ?
                               ADDRESS_BITS : sacpe_pkg::ADDR_W;
    localparam int TAG_SH    = OFF_W + SET_W;
    localparam int TAG_W     = (AW > TAG_SH) ? AW - TAG_SH : 1;
    localparam int ROW_W     = NUM_WAYS * (TAG_W + 2 + WAY_W) + WAY_W;
    localparam int WORD_COST = 100 * (BLOCK_BYTES / 4);
    localparam logic [sacpe_pkg::ADDR_W-1:0] AMASK =
        sacpe_pkg::ADDR_W'((64'd1 << AW) - 64'd1);

    // Control registers.
    sacpe_pkg::t_cfg        r_cfg;
    logic                   r_s1_valid;
    logic                   r_out_valid;
    logic                   r_byp_valid;
    logic [NUM_SETS-1:0]    r_set_init;

    // Payload registers.
    logic                   r_s1_store;
    logic [SET_IW-1:0]      r_s1_set;
    logic [TAG_W-1:0]       r_s1_tag;
    logic [ROW_W-1:0]       r_byp_row;
    sacpe_pkg::t_rsp        r_out_rsp;

    logic                   n_byp_valid;
    logic                   s1_fire;
    logic                   in_ready;
    logic                   in_acc;
    logic [sacpe_pkg::ADDR_W-1:0] in_addr;
    logic [SET_IW-1:0]      in_set;
    logic [TAG_W-1:0]       in_tag;
    logic [SET_IW-1:0]      rd_set;
    logic [ROW_W-1:0]       ram_rdata;
    logic [ROW_W-1:0]       reset_row;
    logic [ROW_W-1:0]       cur_row;
    logic [ROW_W-1:0]       new_row;

    logic [NUM_WAYS-1:0][TAG_W-1:0] cur_tags, new_tags;
    logic [NUM_WAYS-1:0]            cur_valid, new_valid;
    logic [NUM_WAYS-1:0]            cur_dirty, new_dirty;
    logic [NUM_WAYS-1:0][WAY_W-1:0] cur_rank, new_rank, rst_rank;
    logic [WAY_W-1:0]               cur_fifo, new_fifo;
    sacpe_pkg::t_rsp                pol_rsp;

    // Handshake: the lookup stage moves on when the result register is free or its word is taken.
    assign s1_fire     = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign in_ready    = !r_s1_valid || s1_fire;
    assign in_acc      = i_req.valid && in_ready;
    assign i_req.ready = in_ready;

    // Address split into set and tag.
    assign in_addr = i_req.address & AMASK;
    assign in_set  = SET_IW'((in_addr >> OFF_W) % NUM_SETS);
    assign in_tag  = TAG_W'(in_addr >> TAG_SH);

    // The RAM keeps reading the held set while the lookup stage stalls.
    assign rd_set = in_acc ? in_set : r_s1_set;

    sacpe_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_set),
        .i_wdata (new_row),
        .i_raddr (rd_set),
        .o_rdata (ram_rdata)
    );

    // Row of a set that was never written since reset.
    always_comb begin
        for (int i = 0; i < NUM_WAYS; i++) begin
            rst_rank[i] = WAY_W'(i);
        end
        reset_row = {{(NUM_WAYS * TAG_W){1'b0}}, {NUM_WAYS{1'b0}}, {NUM_WAYS{1'b0}},
                     rst_rank, {WAY_W{1'b0}}};
    end

    // Current set row: forwarded write, RAM data, or the reset row.
    assign cur_row = r_byp_valid ? r_byp_row :
                     (r_set_init[r_s1_set] ? ram_rdata : reset_row);
    assign {cur_tags, cur_valid, cur_dirty, cur_rank, cur_fifo} = cur_row;
    assign new_row = {new_tags, new_valid, new_dirty, new_rank, new_fifo};

    sacpe_policy #(
        .NUM_WAYS  (NUM_WAYS),
        .TAG_W     (TAG_W),
        .WAY_W     (WAY_W),
        .WORD_COST (WORD_COST)
    ) u_policy (
        .i_store (r_s1_store),
        .i_tag   (r_s1_tag),
        .i_cfg   (r_cfg),
        .i_tags  (cur_tags),
        .i_valid (cur_valid),
        .i_dirty (cur_dirty),
        .i_rank  (cur_rank),
        .i_fifo  (cur_fifo),
        .o_tags  (new_tags),
        .o_valid (new_valid),
        .o_dirty (new_dirty),
        .o_rank  (new_rank),
        .o_fifo  (new_fifo),
        .o_rsp   (pol_rsp)
    );

    // Forward the written row when the same set is read at the same edge.
    assign n_byp_valid = s1_fire && (rd_set == r_s1_set);

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wr_thru  <= 1'b0;
            r_cfg.wr_alloc <= 1'b1;
            r_cfg.lru      <= 1'b1;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_byp_valid    <= 1'b0;
            r_set_init     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    sacpe_pkg::CFG_WRITE_THROUGH:  r_cfg.wr_thru  <= i_cfg_wr_data[0];
                    sacpe_pkg::CFG_WRITE_ALLOCATE: r_cfg.wr_alloc <= i_cfg_wr_data[0];
                    sacpe_pkg::CFG_LRU:            r_cfg.lru      <= i_cfg_wr_data[0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid          <= 1'b1;
                r_set_init[r_s1_set] <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            r_byp_valid <= n_byp_valid;
        end
    end

    // Payload of the lookup stage, forwarding path and result.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_store <= (i_req.func == sacpe_pkg::FUNC_STORE);
            r_s1_set   <= in_set;
            r_s1_tag   <= in_tag;
        end
        if (s1_fire) begin
            r_byp_row <= new_row;
            r_out_rsp <= pol_rsp;
        end
    end

    assign o_rsp.valid               = r_out_valid;
    assign o_rsp.hit                 = r_out_rsp.hit;
    assign o_rsp.way_used            = r_out_rsp.way_used;
    assign o_rsp.victim_written_back = r_out_rsp.victim_written_back;
    assign o_rsp.access_cycles       = r_out_rsp.access_cycles;

endmodule

// ===== design/sacpe_ram.sv =====
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module sacpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; a read at the address being written returns the old row.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/sacpe_policy.sv =====
// ============================================================================
// Cache set policy
// Tag lookup, fill and eviction choice, and the set update for one access.
// ============================================================================
module sacpe_policy #(
    parameter int NUM_WAYS  = 4,
    parameter int TAG_W     = 22,
    parameter int WAY_W     = 2,
    parameter int WORD_COST = 400
) (
    input  logic                              i_store,
    input  logic [TAG_W-1:0]                  i_tag,
    input  sacpe_pkg::t_cfg                   i_cfg,
    input  logic [NUM_WAYS-1:0][TAG_W-1:0]    i_tags,
    input  logic [NUM_WAYS-1:0]               i_valid,
    input  logic [NUM_WAYS-1:0]               i_dirty,
    input  logic [NUM_WAYS-1:0][WAY_W-1:0]    i_rank,
    input  logic [WAY_W-1:0]                  i_fifo,
    output logic [NUM_WAYS-1:0][TAG_W-1:0]    o_tags,
    output logic [NUM_WAYS-1:0]               o_valid,
    output logic [NUM_WAYS-1:0]               o_dirty,
    output logic [NUM_WAYS-1:0][WAY_W-1:0]    o_rank,
    output logic [WAY_W-1:0]                  o_fifo,
    output sacpe_pkg::t_rsp                   o_rsp
);

    localparam logic [31:0]      COST     = 32'(WORD_COST);
    localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(NUM_WAYS - 1);

    logic             hit_found;
    logic [WAY_W-1:0] hit_way;
    logic             free_found;
    logic [WAY_W-1:0] free_way;
    logic [WAY_W-1:0] lru_way;
    logic [WAY_W-1:0] victim;
    logic [WAY_W-1:0] way;
    logic             fill;
    logic             evict;
    logic             wback;
    logic             touch;
    logic [WAY_W-1:0] way_rank;
    logic [1:0]       words;
    logic [31:0]      cycles;

    // Tag match, lowest free way and least recently used way.
    always_comb begin
        hit_found  = 1'b0;
        hit_way    = '0;
        free_found = 1'b0;
        free_way   = '0;
        lru_way    = '0;
        for (int i = NUM_WAYS - 1; i >= 0; i--) begin
            if (i_valid[i] && i_tags[i] == i_tag) begin
                hit_found = 1'b1;
                hit_way   = WAY_W'(i);
            end
            if (!i_valid[i]) begin
                free_found = 1'b1;
                free_way   = WAY_W'(i);
            end
        end
        for (int i = 0; i < NUM_WAYS; i++) begin
            if (i_rank[i] == LAST_WAY) begin
                lru_way = WAY_W'(i);
            end
        end
    end

    // Decide what the access does to the set.
    assign fill     = !hit_found && !(i_store && !i_cfg.wr_alloc);
    assign evict    = fill && !free_found;
    assign victim   = i_cfg.lru ? lru_way : i_fifo;
    assign way      = hit_found ? hit_way : (free_found ? free_way : victim);
    assign wback    = evict && i_dirty[victim];
    assign touch    = i_cfg.lru && (hit_found || fill);
    assign way_rank = i_rank[way];

    // Next contents of the set.
    always_comb begin
        o_tags  = i_tags;
        o_valid = i_valid;
        o_dirty = i_dirty;
        o_rank  = i_rank;
        o_fifo  = i_fifo;
        if (hit_found && i_store && !i_cfg.wr_thru) begin
            o_dirty[way] = 1'b1;
        end
        if (fill) begin
            o_tags[way]  = i_tag;
            o_valid[way] = 1'b1;
            o_dirty[way] = i_store && !i_cfg.wr_thru;
        end
        if (evict && !i_cfg.lru) begin
            o_fifo = (victim == LAST_WAY) ? '0 : victim + WAY_W'(1);
        end
        // Move the used way to the front and age the ways that were ahead of it.
        if (touch) begin
            for (int i = 0; i < NUM_WAYS; i++) begin
                if (i_rank[i] < way_rank) begin
                    o_rank[i] = i_rank[i] + WAY_W'(1);
                end
            end
            o_rank[way] = '0;
        end
    end

    // Words moved to or from memory, and the charged cycles.
    always_comb begin
        words = 2'(fill) + 2'(wback)
              + 2'(i_store && (i_cfg.wr_thru || (!hit_found && !fill)));
        cycles = 32'd1 + 32'(words) * COST;
        o_rsp.hit                 = hit_found;
        o_rsp.way_used            = (hit_found || fill) ? sacpe_pkg::WAY_OUT_W'(way) : '0;
        o_rsp.victim_written_back = wback;
        o_rsp.access_cycles       = (cycles > 32'(sacpe_pkg::CYC_MAX)) ?
                                    sacpe_pkg::CYC_MAX : cycles[sacpe_pkg::CYC_W-1:0];
    end

endmodule

// ===== design/sacpe_checker.sv =====
// ============================================================================
// Cache policy engine checker
// Port-level assertions on the request and response channels.
// ============================================================================
module sacpe_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic                           i_out_hit,
    input logic                           i_out_wb,
    input logic [sacpe_pkg::CYC_W-1:0]    i_out_cycles
);

    // A stalled result word stays on the port unchanged.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_cycles)
                                        && $stable(i_out_hit) && $stable(i_out_wb))
        else $error("result word changed while stalled");

    // A result appearing on an empty port comes from an accepted word that passed the lookup stage.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result appeared without a matching accepted word");

    // A hit never evicts, so it never writes a victim back.
    a_hit_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_hit |-> !i_out_wb)
        else $error("hit reported a victim write-back");

    // Every access is charged a nonzero cycle count.
    a_cost_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_cycles != '0)
        else $error("access charged zero cycles");

endmodule

bind set_assoc_cache_policy_engine sacpe_checker u_sacpe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_out_hit    (o_rsp.hit),
    .i_out_wb     (o_rsp.victim_written_back),
    .i_out_cycles (o_rsp.access_cycles)
);
